FILE: rtl/spi_register_frame_slave_unit_defines.svh
// Assertion helpers shared by the frame slave RTL.
`ifndef SPI_REGISTER_FRAME_SLAVE_UNIT_DEFINES_SVH
`define SPI_REGISTER_FRAME_SLAVE_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SRFS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SRFS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/srfs_pkg.sv
`default_nettype none
package srfs_pkg;

  // Default sizes of the frame queue and the register table.
  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_REG_COUNT   = 16;

  // Depths of the request queue and the result queue.
  localparam int FRONT_DEPTH = 2;
  localparam int OUT_DEPTH   = 4;

  // Reset value of the frame synchronization byte.
  localparam logic [7:0] SYNC_RESET = 8'hFF;

  // Configuration register select (paddr bit 2).
  localparam logic ADDR_IDX_SYNC = 1'b0;

  // Request type codes on the input port.
  localparam logic [2:0] REQ_RX  = 3'd0;
  localparam logic [2:0] REQ_TXE = 3'd1;
  localparam logic [2:0] REQ_POP = 3'd2;
  localparam logic [2:0] REQ_WR  = 3'd3;
  localparam logic [2:0] REQ_SET = 3'd4;
  localparam logic [2:0] REQ_CLR = 3'd5;

  // Operation codes after classification.
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_RX   = 3'd1;
  localparam logic [2:0] OP_TXE  = 3'd2;
  localparam logic [2:0] OP_POP  = 3'd3;
  localparam logic [2:0] OP_WR   = 3'd4;
  localparam logic [2:0] OP_SET  = 3'd5;
  localparam logic [2:0] OP_CLR  = 3'd6;

  // Request as it arrives on the input port.
  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  rx_byte;
    logic [6:0]  reg_address;
    logic [15:0] reg_value;
  } srfs_in_t;

  // Request after classification.
  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  rx_byte;
    logic [6:0]  reg_address;
    logic [15:0] reg_value;
  } srfs_item_t;

  // Result as delivered on the output port.
  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        cmd_valid;
    logic [6:0]  cmd_address;
    logic [15:0] cmd_data;
    logic        cmd_checksum_ok;
    logic        has_data;
    logic        fifo_full;
  } srfs_out_t;

  // Frame checksum: inverted xor of address, data low and data high.
  function automatic logic [7:0] checksum8(input logic [7:0] addr, input logic [15:0] data);
    checksum8 = ~(addr ^ data[7:0] ^ data[15:8]);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/spi_register_frame_slave_unit.sv
// Data path: a request passes through the request queue, the execute stage and the result queue.
// Throughput: one request per cycle while the result queue has room, one result per request, set by the single
// read-modify-write execute stage on the register table and the frame queue memory.
// Reset: synchronous, active high; clears the parser, queue pointers, table valid bits
// and both handshake queues, sets the sync byte to 0xFF; no memory clearing pass.
`default_nettype none
`include "spi_register_frame_slave_unit_defines.svh"
module spi_register_frame_slave_unit import srfs_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int REG_COUNT   = DEF_REG_COUNT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire srfs_in_t    item,
  output logic             empty,
  input  wire logic        pop,
  output srfs_out_t        result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic                         sync_byte;
  logic [7:0]                   sync_reg;
  srfs_item_t                   head;
  logic                         head_empty;
  logic                         take;
  logic                         res_full;
  logic                         res_wr;
  srfs_out_t                    res;
  logic [$bits(srfs_out_t)-1:0] out_bits;

  // Configuration port: the sync byte register.
  assign pready    = 1'b1;
  assign sync_byte = psel && penable && pwrite && (paddr[2] == ADDR_IDX_SYNC);
  assign prdata    = (paddr[2] == ADDR_IDX_SYNC) ? {24'd0, sync_reg} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_reg <= SYNC_RESET;
    end else if (sync_byte) begin
      sync_reg <= pwdata[7:0];
    end
  end

  // Request intake and classification.
  srfs_front u_front (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .item (item),
    .full (full),
    .take (take),
    .head (head),
    .empty(head_empty)
  );

  // Frame parser, register table and frame queue.
  srfs_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .REG_COUNT  (REG_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .sync_byte (sync_reg),
    .head      (head),
    .head_empty(head_empty),
    .take      (take),
    .res_full  (res_full),
    .res_wr    (res_wr),
    .res       (res)
  );

  // Result queue toward the consumer.
  srfs_fifo #(
    .WIDTH($bits(srfs_out_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_wr),
    .wr_data(res),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(out_bits),
    .empty  (empty)
  );

  assign result = srfs_out_t'(out_bits);

  // Both queues come out of reset empty.
  `SRFS_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, empty && !full, "queues not empty after reset")
  // A single request never both transmits a byte and pops a frame.
  `SRFS_ASSERT_NOW(a_one_action, clk, rst, !empty, !(result.tx_valid && result.cmd_valid),
                   "result carries both a tx byte and a popped frame")
  // A full frame queue always reports data.
  `SRFS_ASSERT_NOW(a_full_has_data, clk, rst, !empty && result.fifo_full, result.has_data,
                   "frame queue full without data")
  // An accepted request is visible to the execution side in the next cycle.
  `SRFS_ASSERT_NEXT(a_front_holds, clk, rst, push && !full, !head_empty,
                    "accepted request missing from the request queue")

endmodule
`default_nettype wire

FILE: rtl/srfs_ram.sv
`default_nettype none
module srfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port and a registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/srfs_fifo.sv
`default_nettype none
module srfs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty
);

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/srfs_front.sv
`default_nettype none
module srfs_front import srfs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire srfs_in_t   item,
  output logic            full,
  input  wire logic       take,
  output srfs_item_t      head,
  output logic            empty
);

  srfs_item_t                    cls;
  logic [$bits(srfs_item_t)-1:0] head_bits;

  // Classify the request type into an operation code.
  always_comb begin
    cls.rx_byte     = item.rx_byte;
    cls.reg_address = item.reg_address;
    cls.reg_value   = item.reg_value;
    case (item.req_type)
      REQ_RX:  cls.op = OP_RX;
      REQ_TXE: cls.op = OP_TXE;
      REQ_POP: cls.op = OP_POP;
      REQ_WR:  cls.op = OP_WR;
      REQ_SET: cls.op = OP_SET;
      REQ_CLR: cls.op = OP_CLR;
      default: cls.op = OP_NONE;
    endcase
  end

  // Short queue that decouples the input from the execution side.
  srfs_fifo #(
    .WIDTH($bits(srfs_item_t)),
    .DEPTH(FRONT_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(cls),
    .full   (full),
    .rd_en  (take),
    .rd_data(head_bits),
    .empty  (empty)
  );

  assign head = srfs_item_t'(head_bits);

endmodule
`default_nettype wire

FILE: rtl/srfs_back.sv
`default_nettype none
module srfs_back import srfs_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int REG_COUNT   = DEF_REG_COUNT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] sync_byte,
  input  wire srfs_item_t head,
  input  wire logic       head_empty,
  output logic            take,
  input  wire logic       res_full,
  output logic            res_wr,
  output srfs_out_t       res
);

  localparam int QIDX = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int RIDX = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam logic [QIDX-1:0] QLAST = QIDX'(QUEUE_DEPTH - 1);

  // Frame parser phases.
  localparam logic [2:0] PH_SYNC  = 3'd0;
  localparam logic [2:0] PH_ADDR  = 3'd1;
  localparam logic [2:0] PH_RX_HI = 3'd2;
  localparam logic [2:0] PH_RX_LO = 3'd3;
  localparam logic [2:0] PH_RX_CK = 3'd4;
  localparam logic [2:0] PH_TX_HI = 3'd5;
  localparam logic [2:0] PH_TX_LO = 3'd6;
  localparam logic [2:0] PH_TX_CK = 3'd7;

  function automatic logic [QIDX-1:0] q_inc(input logic [QIDX-1:0] p);
    q_inc = (p == QLAST) ? '0 : p + 1'b1;
  endfunction

  // Architectural state.
  logic [2:0]           phase, phase_next;
  logic [31:0]          fword, fword_next;
  logic                 tx_active, tx_active_next;
  logic [QIDX-1:0]      qhead, qhead_next;
  logic [QIDX-1:0]      qtail, qtail_next;
  logic                 qfull, qfull_next;
  logic [REG_COUNT-1:0] reg_valid;

  // Execute stage registers.
  logic       b_valid;
  srfs_item_t b_item;
  logic       b_reg_byp;
  logic [23:0] b_reg_bdata;
  logic       b_q_byp;
  logic [30:0] b_q_bdata;

  // Memory ports and lookup.
  logic            go;
  logic            b_exec;
  logic [6:0]      a_raddr7;
  logic [RIDX-1:0] a_ridx;
  logic [QIDX-1:0] a_qaddr;
  logic [23:0]     reg_q;
  logic [30:0]     q_q;
  logic            reg_we;
  logic [23:0]     reg_wdata;
  logic            q_we;
  logic [30:0]     q_wdata;
  logic            b_pop;
  logic [6:0]      b_raddr7;
  logic [RIDX-1:0] b_ridx;
  logic            b_in_range;
  logic [23:0]     reg_rd;
  logic [30:0]     q_rd;
  logic [15:0]     d16;

  // The pipeline advances whenever the result queue has room.
  assign go     = !res_full;
  assign take   = go && !head_empty;
  assign b_exec = go && b_valid;
  assign res_wr = b_exec;

  // Read addresses for the request at the head of the queue.
  assign a_raddr7 = (head.op == OP_RX) ? head.rx_byte[6:0] : head.reg_address;
  assign a_ridx   = a_raddr7[RIDX-1:0];
  assign a_qaddr  = b_pop ? q_inc(qtail) : qtail;

  srfs_ram #(.WIDTH(24), .DEPTH(REG_COUNT)) u_reg_ram (
    .clk  (clk),
    .we   (reg_we),
    .waddr(b_ridx),
    .wdata(reg_wdata),
    .re   (go),
    .raddr(a_ridx),
    .rdata(reg_q)
  );

  srfs_ram #(.WIDTH(31), .DEPTH(QUEUE_DEPTH)) u_frame_ram (
    .clk  (clk),
    .we   (q_we),
    .waddr(qhead),
    .wdata(q_wdata),
    .re   (go),
    .raddr(a_qaddr),
    .rdata(q_q)
  );

  // Operand selection: forwarded write, never-written entry, or memory data.
  assign b_raddr7   = (b_item.op == OP_RX) ? b_item.rx_byte[6:0] : b_item.reg_address;
  assign b_ridx     = b_raddr7[RIDX-1:0];
  assign b_in_range = ({25'd0, b_raddr7} < REG_COUNT);
  assign reg_rd     = b_reg_byp ? b_reg_bdata : (reg_valid[b_ridx] ? reg_q : 24'd0);
  assign q_rd       = b_q_byp ? b_q_bdata : q_q;

  // Execute one request.
  always_comb begin
    phase_next     = phase;
    fword_next     = fword;
    tx_active_next = tx_active;
    qhead_next     = qhead;
    qtail_next     = qtail;
    qfull_next     = qfull;
    reg_we         = 1'b0;
    reg_wdata      = 24'd0;
    q_we           = 1'b0;
    q_wdata        = 31'd0;
    b_pop          = 1'b0;
    d16            = 16'd0;
    res            = '0;
    if (b_exec) begin
      case (b_item.op)
        OP_RX: begin
          case (phase)
            PH_SYNC: begin
              if (b_item.rx_byte == sync_byte) begin
                phase_next = PH_ADDR;
              end
            end
            PH_ADDR: begin
              fword_next = {b_item.rx_byte, 24'd0};
              if (b_item.rx_byte[7]) begin
                if (b_in_range) begin
                  fword_next[23:0] = reg_rd;
                end
                phase_next     = PH_TX_HI;
                tx_active_next = 1'b1;
                res.tx_valid   = 1'b1;
                res.tx_byte    = fword_next[23:16];
              end else begin
                phase_next = PH_RX_HI;
              end
            end
            PH_RX_HI: begin
              fword_next = fword | {8'd0, b_item.rx_byte, 16'd0};
              phase_next = PH_RX_LO;
            end
            PH_RX_LO: begin
              fword_next = fword | {16'd0, b_item.rx_byte, 8'd0};
              phase_next = PH_RX_CK;
            end
            PH_RX_CK: begin
              fword_next = fword | {24'd0, b_item.rx_byte};
              phase_next = PH_SYNC;
              if (!qfull) begin
                q_we       = 1'b1;
                q_wdata    = fword_next[30:0];
                qhead_next = q_inc(qhead);
                qfull_next = (q_inc(qhead) == qtail);
              end
            end
            default: begin
            end
          endcase
        end
        OP_TXE: begin
          if (tx_active) begin
            res.tx_valid = 1'b1;
            if (phase == PH_TX_HI) begin
              res.tx_byte = fword[15:8];
              phase_next  = PH_TX_LO;
            end else if (phase == PH_TX_LO) begin
              res.tx_byte = fword[7:0];
              phase_next  = PH_TX_CK;
            end else begin
              res.tx_byte    = 8'd0;
              tx_active_next = 1'b0;
              phase_next     = PH_SYNC;
            end
          end
        end
        OP_POP: begin
          if ((qhead != qtail) || qfull) begin
            b_pop               = 1'b1;
            qtail_next          = q_inc(qtail);
            qfull_next          = 1'b0;
            res.cmd_valid       = 1'b1;
            res.cmd_address     = q_rd[30:24];
            res.cmd_data        = q_rd[23:8];
            res.cmd_checksum_ok = (q_rd[7:0] == checksum8({1'b0, q_rd[30:24]}, q_rd[23:8]));
          end
        end
        OP_WR, OP_SET, OP_CLR: begin
          if (b_in_range) begin
            d16 = reg_rd[23:8];
            if (b_item.op == OP_WR) begin
              d16 = b_item.reg_value;
            end else if (b_item.op == OP_SET) begin
              d16 = d16 | b_item.reg_value;
            end else begin
              d16 = d16 & ~b_item.reg_value;
            end
            reg_we    = 1'b1;
            reg_wdata = {d16, checksum8({1'b1, b_item.reg_address}, d16)};
          end
        end
        default: begin
        end
      endcase
    end
    res.has_data  = (qhead_next != qtail_next) || qfull_next;
    res.fifo_full = qfull_next;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_SYNC;
      fword     <= 32'd0;
      tx_active <= 1'b0;
      qhead     <= '0;
      qtail     <= '0;
      qfull     <= 1'b0;
      reg_valid <= '0;
      b_valid   <= 1'b0;
    end else begin
      phase     <= phase_next;
      fword     <= fword_next;
      tx_active <= tx_active_next;
      qhead     <= qhead_next;
      qtail     <= qtail_next;
      qfull     <= qfull_next;
      if (reg_we) begin
        reg_valid[b_ridx] <= 1'b1;
      end
      if (go) begin
        b_valid <= !head_empty;
      end
    end
  end

  // Execute stage payload and forwarding of writes that race a read.
  always_ff @(posedge clk) begin
    if (go) begin
      b_item      <= head;
      b_reg_byp   <= reg_we && (b_ridx == a_ridx);
      b_reg_bdata <= reg_wdata;
      b_q_byp     <= q_we && (qhead == a_qaddr);
      b_q_bdata   <= q_wdata;
    end
  end

endmodule
`default_nettype wire

FILE: bench/tb_spi_register_frame_slave_unit.sv
`timescale 1ns / 100ps

module tb_spi_register_frame_slave_unit;
  import srfs_pkg::*;

  // Request codes that the block treats as no-ops.
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;

  // Byte address of the sync byte register.
  localparam logic [2:0] SYNC_REG_ADDR = {ADDR_IDX_SYNC, 2'b00};

  // Cycles with no accepted request, result or register access before giving up.
  localparam int unsigned STALL_LIMIT = 2000;

  // Parser phases of the frame engine.
  typedef enum logic [2:0] {
    FP_SYNC, FP_ADDR, FP_RX_HI, FP_RX_LO, FP_RX_CK, FP_TX_HI, FP_TX_LO, FP_TX_CK
  } frame_phase_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  srfs_in_t    item = '0;
  logic        empty;
  logic        pop = 1'b0;
  srfs_out_t   result;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Frame engine copy: parser, frame queue, register table and sync byte.
  frame_phase_e fe_phase = FP_SYNC;
  logic [31:0]  fe_word = '0;
  logic         fe_tx_busy = 1'b0;
  logic [30:0]  fe_store [DEF_QUEUE_DEPTH];
  int unsigned  fe_head = 0;
  int unsigned  fe_tail = 0;
  logic         fe_full = 1'b0;
  logic [23:0]  fe_regs [DEF_REG_COUNT] = '{default: '0};
  logic [7:0]   fe_sync = SYNC_RESET;

  // Requests waiting to be sent and status reports the engine owes us.
  srfs_in_t  host_events [$];
  srfs_out_t engine_reports [$];

  int unsigned events_staged = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned faults = 0;
  int unsigned cfg_writes = 0;
  int unsigned frames_queued = 0;
  int unsigned frames_dropped = 0;
  int unsigned frames_popped = 0;
  int unsigned reads_started = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  int unsigned quiet_cycles = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;

  spi_register_frame_slave_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .item    (item),
    .empty   (empty),
    .pop     (pop),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Inverted xor of address, data high and data low.
  function automatic logic [7:0] frame_sum(input logic [7:0] a, input logic [15:0] d);
    return ~(a ^ d[15:8] ^ d[7:0]);
  endfunction

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic void add_event(input logic [2:0] kind, input logic [7:0] rx,
                                    input logic [6:0] ra, input logic [15:0] rv);
    srfs_in_t ev;
    ev.req_type    = kind;
    ev.rx_byte     = rx;
    ev.reg_address = ra;
    ev.reg_value   = rv;
    host_events.push_back(ev);
    events_staged++;
  endfunction

  function automatic void note_fault(input string what, input logic [31:0] want,
                                     input logic [31:0] got);
    faults++;
    if (faults <= 10)
      $display("MISMATCH %s at result %0d: expected 0x%0h, got 0x%0h",
               what, results_seen, want, got);
  endfunction

  // Advance the frame engine by one request and record the status it reports.
  function automatic void frame_engine_step(input srfs_in_t req);
    srfs_out_t   rep;
    logic [6:0]  ra;
    logic [15:0] word;
    logic [30:0] fr;
    rep = '0;
    case (req.req_type)
      REQ_RX: begin
        case (fe_phase)
          FP_SYNC: begin
            if (req.rx_byte == fe_sync) fe_phase = FP_ADDR;
          end
          FP_ADDR: begin
            fe_word = {req.rx_byte, 24'h0};
            if (req.rx_byte[7]) begin
              // Register read: the high byte goes out at once.
              ra = req.rx_byte[6:0];
              if (ra < DEF_REG_COUNT) fe_word[23:0] = fe_regs[ra];
              fe_phase = FP_TX_HI;
              fe_tx_busy = 1'b1;
              rep.tx_valid = 1'b1;
              rep.tx_byte = fe_word[23:16];
              reads_started++;
            end else begin
              fe_phase = FP_RX_HI;
            end
          end
          FP_RX_HI: begin
            fe_word[23:16] = req.rx_byte;
            fe_phase = FP_RX_LO;
          end
          FP_RX_LO: begin
            fe_word[15:8] = req.rx_byte;
            fe_phase = FP_RX_CK;
          end
          FP_RX_CK: begin
            fe_word[7:0] = req.rx_byte;
            fe_phase = FP_SYNC;
            // A full queue drops the frame.
            if (fe_full) begin
              frames_dropped++;
            end else begin
              fe_store[fe_head] = fe_word[30:0];
              fe_head = (fe_head + 1 >= DEF_QUEUE_DEPTH) ? 0 : fe_head + 1;
              if (fe_head == fe_tail) fe_full = 1'b1;
              frames_queued++;
            end
          end
          default: begin
          end
        endcase
      end
      REQ_TXE: begin
        if (fe_tx_busy) begin
          rep.tx_valid = 1'b1;
          if (fe_phase == FP_TX_HI) begin
            rep.tx_byte = fe_word[15:8];
            fe_phase = FP_TX_LO;
          end else if (fe_phase == FP_TX_LO) begin
            rep.tx_byte = fe_word[7:0];
            fe_phase = FP_TX_CK;
          end else begin
            // Trailing zero closes the read.
            rep.tx_byte = 8'h00;
            fe_tx_busy = 1'b0;
            fe_phase = FP_SYNC;
          end
        end
      end
      REQ_POP: begin
        if (fe_head != fe_tail || fe_full) begin
          fr = fe_store[fe_tail];
          fe_tail = (fe_tail + 1 >= DEF_QUEUE_DEPTH) ? 0 : fe_tail + 1;
          fe_full = 1'b0;
          rep.cmd_valid = 1'b1;
          rep.cmd_address = fr[30:24];
          rep.cmd_data = fr[23:8];
          rep.cmd_checksum_ok = (fr[7:0] == frame_sum({1'b0, fr[30:24]}, fr[23:8]));
          frames_popped++;
        end
      end
      REQ_WR, REQ_SET, REQ_CLR: begin
        // Host update; addresses past the table are ignored.
        if (req.reg_address < DEF_REG_COUNT) begin
          word = fe_regs[req.reg_address][23:8];
          case (req.req_type)
            REQ_WR:  word = req.reg_value;
            REQ_SET: word = word | req.reg_value;
            default: word = word & ~req.reg_value;
          endcase
          fe_regs[req.reg_address] = {word, frame_sum({1'b1, req.reg_address}, word)};
        end
      end
      default: begin
      end
    endcase
    rep.has_data = (fe_head != fe_tail) || fe_full;
    rep.fifo_full = fe_full;
    engine_reports.push_back(rep);
  endfunction

  // Compare one delivered status report with the oldest one owed.
  function automatic void check_report(input srfs_out_t got);
    srfs_out_t want;
    results_seen++;
    if (engine_reports.size() == 0) begin
      note_fault("result with nothing outstanding", 32'd0, 32'(got));
      return;
    end
    want = engine_reports.pop_front();
    if (got.tx_valid !== want.tx_valid)
      note_fault("tx_valid", 32'(want.tx_valid), 32'(got.tx_valid));
    if (got.tx_byte !== want.tx_byte)
      note_fault("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
    if (got.cmd_valid !== want.cmd_valid)
      note_fault("cmd_valid", 32'(want.cmd_valid), 32'(got.cmd_valid));
    if (got.cmd_address !== want.cmd_address)
      note_fault("cmd_address", 32'(want.cmd_address), 32'(got.cmd_address));
    if (got.cmd_data !== want.cmd_data)
      note_fault("cmd_data", 32'(want.cmd_data), 32'(got.cmd_data));
    if (got.cmd_checksum_ok !== want.cmd_checksum_ok)
      note_fault("cmd_checksum_ok", 32'(want.cmd_checksum_ok), 32'(got.cmd_checksum_ok));
    if (got.has_data !== want.has_data)
      note_fault("has_data", 32'(want.has_data), 32'(got.has_data));
    if (got.fifo_full !== want.fifo_full)
      note_fault("fifo_full", 32'(want.fifo_full), 32'(got.fifo_full));
  endfunction

  // Request driver: one request per handshake, random gaps between them.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      send_wait = 0;
    end else begin
      if (push && !full) begin
        frame_engine_step(item);
        items_sent++;
        if ($urandom_range(0, 59) == 0) send_calm = !send_calm;
        send_wait = draw_wait(send_calm);
      end
      if (push && full) begin
        // Hold the request until it is taken.
      end else if (send_wait > 0) begin
        send_wait--;
        push <= 1'b0;
      end else if (host_events.size() > 0) begin
        item <= host_events.pop_front();
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result monitor: takes reports with random stalls and checks each one.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      recv_wait = 0;
    end else begin
      if (pop && !empty) begin
        check_report(result);
        if ($urandom_range(0, 59) == 0) recv_calm = !recv_calm;
        recv_wait = draw_wait(recv_calm);
      end
      if (recv_wait > 0) begin
        recv_wait--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
        $display("spi_register_frame_slave_unit test failed");
        $finish;
      end
    end
  end

  // Let every staged request be taken and every owed report arrive, then let the
  // pipeline settle.
  task automatic wait_engine_quiet();
    while (items_sent != events_staged || engine_reports.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the sync byte over APB and read it back.
  task automatic set_sync_byte(input logic [7:0] v);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= SYNC_REG_ADDR;
    pwdata <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    fe_sync = v;
    cfg_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== v) note_fault("sync_byte read-back", 32'(v), 32'(prdata[7:0]));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic: write frames with random content, register reads, pops, host
  // register updates and stray requests.
  task automatic gen_traffic(input int unsigned n_items, input int unsigned pop_pct,
                             input int unsigned frame_pct);
    int unsigned stop_at;
    int unsigned pick;
    logic [6:0]  fa;
    logic [15:0] fd;
    logic [7:0]  ck;
    stop_at = events_staged + n_items;
    while (events_staged < stop_at) begin
      if ($urandom_range(0, 99) < pop_pct) begin
        add_event(REQ_POP, 8'($urandom), 7'($urandom), 16'($urandom));
      end else if ($urandom_range(0, 99) < frame_pct) begin
        // Write frame; about one in five carries a wrong checksum.
        fa = 7'($urandom_range(0, 127));
        fd = 16'($urandom);
        ck = frame_sum({1'b0, fa}, fd);
        if ($urandom_range(0, 4) == 0) ck = ck ^ 8'($urandom_range(1, 255));
        add_event(REQ_RX, fe_sync, 7'($urandom), 16'($urandom));
        add_event(REQ_RX, {1'b0, fa}, 7'($urandom), 16'($urandom));
        add_event(REQ_RX, fd[15:8], 7'($urandom), 16'($urandom));
        add_event(REQ_RX, fd[7:0], 7'($urandom), 16'($urandom));
        add_event(REQ_RX, ck, 7'($urandom), 16'($urandom));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          // Register read, usually drained with exactly three tx-empty events.
          fa = 7'(($urandom_range(0, 4) != 0) ? $urandom_range(0, DEF_REG_COUNT - 1)
                                               : $urandom_range(DEF_REG_COUNT, 127));
          add_event(REQ_RX, fe_sync, 7'($urandom), 16'($urandom));
          add_event(REQ_RX, {1'b1, fa}, 7'($urandom), 16'($urandom));
          repeat (($urandom_range(0, 4) != 0) ? 3 : $urandom_range(0, 5))
            add_event(REQ_TXE, 8'($urandom), 7'($urandom), 16'($urandom));
        end else if (pick < 8) begin
          fa = 7'(($urandom_range(0, 6) != 0) ? $urandom_range(0, DEF_REG_COUNT - 1)
                                               : $urandom_range(0, 127));
          case ($urandom_range(0, 9))
            0:       fd = 16'h0000;
            1:       fd = 16'hFFFF;
            default: fd = 16'($urandom);
          endcase
          add_event(3'($urandom_range(REQ_WR, REQ_CLR)), 8'($urandom), fa, fd);
        end else begin
          repeat ($urandom_range(1, 3))
            add_event(3'($urandom_range(0, 7)), 8'($urandom), 7'($urandom),
                      16'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: idle corner cases, host updates, a full read and write frame
    // exchange, then a read of an address past the table.
    add_event(REQ_POP, 8'h00, 7'h00, 16'h0000);
    add_event(REQ_TXE, 8'h00, 7'h00, 16'h0000);
    add_event(REQ_SPARE6, 8'hFF, 7'h7F, 16'hFFFF);
    add_event(REQ_SPARE7, 8'h00, 7'h00, 16'h0000);
    add_event(REQ_WR, 8'h00, 7'd0, 16'hFFFF);
    add_event(REQ_WR, 8'h00, 7'd15, 16'h1234);
    add_event(REQ_SET, 8'h00, 7'd15, 16'h8001);
    add_event(REQ_CLR, 8'h00, 7'd0, 16'h00FF);
    add_event(REQ_WR, 8'h00, 7'd127, 16'hFFFF);
    add_event(REQ_RX, SYNC_RESET, 7'h00, 16'h0000);
    add_event(REQ_RX, 8'h80, 7'h00, 16'h0000);
    repeat (3) add_event(REQ_TXE, 8'h00, 7'h00, 16'h0000);
    add_event(REQ_RX, SYNC_RESET, 7'h00, 16'h0000);
    add_event(REQ_RX, 8'h7F, 7'h00, 16'h0000);
    add_event(REQ_RX, 8'h00, 7'h00, 16'h0000);
    add_event(REQ_RX, 8'hFF, 7'h00, 16'h0000);
    add_event(REQ_RX, frame_sum(8'h7F, 16'h00FF), 7'h00, 16'h0000);
    add_event(REQ_POP, 8'h00, 7'h00, 16'h0000);
    add_event(REQ_RX, SYNC_RESET, 7'h00, 16'h0000);
    add_event(REQ_RX, 8'hFF, 7'h00, 16'h0000);
    add_event(REQ_RX, 8'h55, 7'h00, 16'h0000);
    repeat (3) add_event(REQ_TXE, 8'h00, 7'h00, 16'h0000);
    wait_engine_quiet();

    // Balanced traffic with the lowest sync byte.
    set_sync_byte(8'h00);
    gen_traffic(150, 25, 45);
    wait_engine_quiet();

    // Frame-heavy traffic with rare pops so that the queue fills and drops.
    set_sync_byte(8'($urandom_range(1, 254)));
    gen_traffic(420, 1, 90);
    wait_engine_quiet();

    // Pop-heavy traffic with the highest sync byte to drain the queue.
    set_sync_byte(8'hFF);
    gen_traffic(170, 40, 45);
    wait_engine_quiet();

    $display("Sent %0d requests and checked %0d reports over %0d sync byte settings.",
             items_sent, results_seen, cfg_writes);
    $display("Frames queued %0d, dropped on full %0d, popped %0d; reads started %0d.",
             frames_queued, frames_dropped, frames_popped, reads_started);
    if (faults == 0 && engine_reports.size() == 0) begin
      $display("spi_register_frame_slave_unit test passed");
    end else begin
      $display("%0d mismatches, %0d reports outstanding", faults, engine_reports.size());
      $display("spi_register_frame_slave_unit test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/srfs_pkg.sv
rtl/srfs_ram.sv
rtl/srfs_fifo.sv
rtl/srfs_front.sv
rtl/srfs_back.sv
rtl/spi_register_frame_slave_unit.sv
bench/tb_spi_register_frame_slave_unit.sv
